// File: src/wlmm_pkg.sv
// wlmm_pkg: shared types, constants and the luma function of the window luma filter
// depends on nothing; used by window_luma_min_max_filter and its testbench
package wlmm_pkg;

  // default sizes
  localparam int DefMaxWidth  = 1024;
  localparam int DefMaxRadius = 6;

  // luma weights, sum shifted right by LumaShift
  localparam int LumaCoefR = 872;
  localparam int LumaCoefG = 2930;
  localparam int LumaCoefB = 296;
  localparam int LumaShift = 12;

  // register reset values
  localparam logic        RstMinMode = 1'b0;
  localparam logic [2:0]  RstRadius  = 3'd1;
  localparam logic [10:0] RstWidth   = 11'd640;
  localparam logic [11:0] RstHeight  = 12'd480;

  // register indexes
  typedef enum logic [1:0] {
    RegMinMode = 2'd0,
    RegRadius  = 2'd1,
    RegWidth   = 2'd2,
    RegHeight  = 2'd3
  } reg_idx_e;

  // input item command
  localparam logic CmdPixel = 1'b0;
  localparam logic CmdFlush = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;
  } out_item_t;

  // luma of a packed r,g,b pixel; the weighted sum stays below 2^20
  function automatic logic [7:0] luma(logic [23:0] px);
    logic [19:0] sum;
    sum = 20'(px[23:16] * 20'(LumaCoefR)) + 20'(px[15:8] * 20'(LumaCoefG))
        + 20'(px[7:0] * 20'(LumaCoefB));
    return sum[19:LumaShift];
  endfunction

endpackage

// File: src/wlmm_ram.sv
// wlmm_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module wlmm_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/window_luma_min_max_filter.sv
// window_luma_min_max_filter: min/max luma window filter over a raster rgb stream
// depends on wlmm_pkg and wlmm_ram
//
// usage: pixels enter in raster order on the in channel (valid/ready, cmd pixel
// or flush); result pixels leave on the out channel (valid/ready). registers
// (min_mode, radius, frame_width, frame_height) sit on an apb port at 4*i, and
// any write restarts the frame. results lag the input by D rows plus D pixels
// (D = r for odd r, else r-1); flush items after the frame drain the tail, one
// result each, and frame_last marks the final one.
// operation: an item that yields no result is taken in the idle state. an item with a result
// scans the window out of the line store, one pixel read per cycle through the
// single read port: side*side reads for an interior pixel, one for a border
// pixel, where side = 2r + (r odd).
// the output register holds a finished item while the next input item is taken;
// when the receiver stalls, the next result waits in the finish state.
// reset clears the state, position counters and registers; the line store holds no reset value.
module window_luma_min_max_filter #(
  parameter int MaxWidth  = wlmm_pkg::DefMaxWidth,
  parameter int MaxRadius = wlmm_pkg::DefMaxRadius
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wlmm_pkg::in_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wlmm_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int Rows  = 2 * MaxRadius + 1;
  localparam int Depth = Rows * MaxWidth;
  localparam int AW    = $clog2(Depth);
  localparam int SW    = $clog2(Rows);
  localparam int CW    = $clog2(MaxWidth);
  localparam int WW    = $clog2(MaxWidth + 1);
  localparam int RW    = $clog2(MaxRadius + 1);
  localparam int NW    = $clog2(2 * MaxRadius + 2);
  localparam int LW    = CW + 14;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_e;

  state_e      state_q;
  logic        min_mode_q;
  logic [2:0]  radius_q;
  logic [10:0] width_q;
  logic [11:0] height_q;

  logic [CW-1:0] in_col_q, out_col_q, base_col_q, cur_col_q;
  logic [11:0]   in_row_q, out_row_q;
  logic [SW-1:0] in_slot_q, out_slot_q, cur_slot_q;
  logic [LW-1:0] in_lin_q, out_lin_q;
  logic [NW-1:0] n_q, i_q, j_q;
  logic          iss_q, dv_q, dv_last_q, first_q;
  logic [23:0]   best_q;
  logic [7:0]    bl_q;

  // effective register values
  logic [WW-1:0] eff_w;
  logic [11:0]   eff_h;
  logic [RW-1:0] eff_r;
  logic [RW-1:0] eff_d;
  logic [NW-1:0] side;
  logic [LW-1:0] lag;

  always_comb begin
    if (width_q == 11'd0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > 32'(MaxWidth)) begin
      eff_w = WW'(MaxWidth);
    end else begin
      eff_w = WW'(width_q);
    end
    eff_h = (height_q == 12'd0) ? 12'd1 : height_q;
    if (radius_q == 3'd0) begin
      eff_r = RW'(1);
    end else if (32'(radius_q) > 32'(MaxRadius)) begin
      eff_r = RW'(MaxRadius);
    end else begin
      eff_r = RW'(radius_q);
    end
    eff_d = eff_r[0] ? eff_r : eff_r - RW'(1);
    side  = NW'({eff_r, 1'b0}) + NW'(eff_r[0]);
    lag   = LW'(eff_d) * LW'(eff_w) + LW'(eff_d);
  end

  // apb register port
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (wlmm_pkg::reg_idx_e'(paddr[3:2]))
      wlmm_pkg::RegMinMode: prdata = {31'd0, min_mode_q};
      wlmm_pkg::RegRadius:  prdata = {29'd0, radius_q};
      wlmm_pkg::RegWidth:   prdata = {21'd0, width_q};
      wlmm_pkg::RegHeight:  prdata = {20'd0, height_q};
      default:              prdata = 32'd0;
    endcase
  end

  // accept decisions
  logic accept, complete, wr_px, emit_now, in_col_wrap, out_load;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign complete    = (in_row_q >= eff_h);
  assign wr_px       = accept && !complete && (in_item_i.cmd == wlmm_pkg::CmdPixel);
  assign in_col_wrap = ({1'b0, in_col_q} + WW'(1)) == eff_w;
  assign emit_now    = accept && (complete ||
                       (wr_px && ((in_lin_q + LW'(1)) > (out_lin_q + lag))));
  assign out_load    = (state_q == S_FIN) && (!out_valid_o || out_ready_i);

  // window placement for the next result
  logic          interior, out_last, out_col_wrap;
  logic [SW-1:0] base_slot;
  always_comb begin
    interior = (out_col_q >= CW'(eff_r))
            && (({1'b0, out_col_q} + WW'(eff_r)) < eff_w)
            && (out_row_q >= 12'(eff_r))
            && (({1'b0, out_row_q} + 13'(eff_r)) < {1'b0, eff_h});
    if (out_slot_q >= SW'(eff_r)) begin
      base_slot = out_slot_q - SW'(eff_r);
    end else begin
      base_slot = out_slot_q + SW'(Rows) - SW'(eff_r);
    end
    out_col_wrap = ({1'b0, out_col_q} + WW'(1)) == eff_w;
    out_last     = ((out_row_q + 12'd1) == eff_h) && out_col_wrap;
  end

  // line store
  logic          ram_we;
  logic [AW-1:0] waddr, raddr;
  logic [23:0]   wdata, rdata;
  assign ram_we = wr_px;
  assign waddr  = AW'(in_slot_q) * AW'(MaxWidth) + AW'(in_col_q);
  assign wdata  = {in_item_i.in_red, in_item_i.in_green, in_item_i.in_blue};
  assign raddr  = AW'(cur_slot_q) * AW'(MaxWidth) + AW'(cur_col_q);

  wlmm_ram #(
    .Width (24),
    .Depth (Depth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (iss_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // scan step and compare
  logic       j_wrap, last_issue, better;
  logic [7:0] rd_luma;
  assign j_wrap     = (j_q + NW'(1)) == n_q;
  assign last_issue = j_wrap && ((i_q + NW'(1)) == n_q);
  assign rd_luma    = wlmm_pkg::luma(rdata);
  assign better     = min_mode_q ? (rd_luma < bl_q) : (rd_luma > bl_q);

  // control, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_mode_q  <= wlmm_pkg::RstMinMode;
      radius_q    <= wlmm_pkg::RstRadius;
      width_q     <= wlmm_pkg::RstWidth;
      height_q    <= wlmm_pkg::RstHeight;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slot_q   <= '0;
      in_lin_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slot_q  <= '0;
      out_lin_q   <= '0;
      iss_q       <= 1'b0;
      dv_q        <= 1'b0;
      dv_last_q   <= 1'b0;
      first_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      dv_q      <= iss_q;
      dv_last_q <= iss_q && last_issue;

      unique case (state_q)
        S_IDLE: begin
          if (wr_px) begin
            in_lin_q <= in_lin_q + LW'(1);
            if (in_col_wrap) begin
              in_col_q  <= '0;
              in_row_q  <= in_row_q + 12'd1;
              in_slot_q <= (in_slot_q == SW'(Rows - 1)) ? '0 : in_slot_q + SW'(1);
            end else begin
              in_col_q <= in_col_q + CW'(1);
            end
          end
          if (emit_now) begin
            state_q    <= S_SCAN;
            iss_q      <= 1'b1;
            first_q    <= 1'b1;
            i_q        <= '0;
            j_q        <= '0;
            n_q        <= interior ? side : NW'(1);
            cur_slot_q <= interior ? base_slot : out_slot_q;
            cur_col_q  <= interior ? out_col_q - CW'(eff_r) : out_col_q;
            base_col_q <= interior ? out_col_q - CW'(eff_r) : out_col_q;
          end
        end
        S_SCAN: begin
          // issue one read a cycle
          if (iss_q) begin
            if (j_wrap) begin
              j_q        <= '0;
              cur_col_q  <= base_col_q;
              cur_slot_q <= (cur_slot_q == SW'(Rows - 1)) ? '0 : cur_slot_q + SW'(1);
              i_q        <= i_q + NW'(1);
              if (last_issue) begin
                iss_q <= 1'b0;
              end
            end else begin
              j_q       <= j_q + NW'(1);
              cur_col_q <= cur_col_q + CW'(1);
            end
          end
          // keep the first extreme pixel in scan order
          if (dv_q) begin
            if (first_q || better) begin
              best_q  <= rdata;
              bl_q    <= rd_luma;
              first_q <= 1'b0;
            end
            if (dv_last_q) begin
              state_q <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_load) begin
            out_item_o.out_red    <= best_q[23:16];
            out_item_o.out_green  <= best_q[15:8];
            out_item_o.out_blue   <= best_q[7:0];
            out_item_o.frame_last <= out_last;
            state_q               <= S_IDLE;
            if (out_last) begin
              in_col_q   <= '0;
              in_row_q   <= '0;
              in_slot_q  <= '0;
              in_lin_q   <= '0;
              out_col_q  <= '0;
              out_row_q  <= '0;
              out_slot_q <= '0;
              out_lin_q  <= '0;
            end else begin
              out_lin_q <= out_lin_q + LW'(1);
              if (out_col_wrap) begin
                out_col_q  <= '0;
                out_row_q  <= out_row_q + 12'd1;
                out_slot_q <= (out_slot_q == SW'(Rows - 1)) ? '0 : out_slot_q + SW'(1);
              end else begin
                out_col_q <= out_col_q + CW'(1);
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // register writes restart the frame
      if (cfg_we) begin
        unique case (wlmm_pkg::reg_idx_e'(paddr[3:2]))
          wlmm_pkg::RegMinMode: min_mode_q <= pwdata[0];
          wlmm_pkg::RegRadius:  radius_q   <= pwdata[2:0];
          wlmm_pkg::RegWidth:   width_q    <= pwdata[10:0];
          wlmm_pkg::RegHeight:  height_q   <= pwdata[11:0];
          default:              min_mode_q <= min_mode_q;
        endcase
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_slot_q  <= '0;
        in_lin_q   <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_slot_q <= '0;
        out_lin_q  <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  // results never run ahead of the input
  a_out_behind_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_lin_q <= in_lin_q) else $error("result count passed input count");

  // no read in flight while a new item is taken
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!iss_q && !dv_q)) else $error("scan active while idle");

  // the last compare of a scan leads to the finish state
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && dv_q && dv_last_q) |=> (state_q == S_FIN))
    else $error("scan did not finish");
`endif

endmodule

// File: verif/window_luma_min_max_filter_test.sv
// window_luma_min_max_filter_test: self-checking testbench for the window luma filter
// depends on wlmm_pkg and window_luma_min_max_filter; drives items, apb writes, checks results
`timescale 1ns / 1ps

module window_luma_min_max_filter_test;

  localparam int StoreRows  = 2 * wlmm_pkg::DefMaxRadius + 1;
  localparam int SettleCyc  = 200;
  localparam int StallLimit = 5000;
  localparam int ItemTarget = 750;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  wlmm_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  wlmm_pkg::out_item_t out_item;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  window_luma_min_max_filter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // filter state mirrored by the predictor
  logic [23:0] line_mem [StoreRows*wlmm_pkg::DefMaxWidth];
  int unsigned in_col, in_row, out_col, out_row;
  logic        cfg_min;
  logic [2:0]  cfg_radius;
  logic [10:0] cfg_width;
  logic [11:0] cfg_height;
  bit          frame_closed;

  wlmm_pkg::out_item_t expected_q [$];
  int          n_fail, n_items, n_results, n_frames, n_phases;
  int          send_idle_pct, recv_idle_pct;
  bit          hold_done;

  function automatic int unsigned eff_radius();
    int unsigned r;
    r = cfg_radius;
    if (r < 1) r = 1;
    if (r > wlmm_pkg::DefMaxRadius) r = wlmm_pkg::DefMaxRadius;
    return r;
  endfunction

  function automatic int unsigned eff_width();
    int unsigned w;
    w = cfg_width;
    if (w < 1) w = 1;
    if (w > wlmm_pkg::DefMaxWidth) w = wlmm_pkg::DefMaxWidth;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (cfg_height < 1) ? 1 : cfg_height;
  endfunction

  function automatic int unsigned mem_slot(int unsigned row, int unsigned col);
    return (row % StoreRows) * wlmm_pkg::DefMaxWidth + (col % wlmm_pkg::DefMaxWidth);
  endfunction

  function automatic int unsigned brightness(logic [23:0] p);
    return (int'(p[23:16]) * wlmm_pkg::LumaCoefR + int'(p[15:8]) * wlmm_pkg::LumaCoefG
            + int'(p[7:0]) * wlmm_pkg::LumaCoefB) >> wlmm_pkg::LumaShift;
  endfunction

  // produce the result for the current output position and advance it
  task automatic emit_result(output wlmm_pkg::out_item_t res);
    int unsigned w, h, r, side, bl, l, oy, ox;
    logic [23:0] pick, px;
    bit first, better, fin;
    w = eff_width();
    h = eff_height();
    r = eff_radius();
    oy = out_row;
    ox = out_col;
    pick = line_mem[mem_slot(oy, ox)];
    if (ox >= r && ox + r < w && oy >= r && oy + r < h) begin
      side = 2 * r + (r & 1);
      first = 1'b1;
      bl = 0;
      for (int i = 0; i < side; i++) begin
        for (int j = 0; j < side; j++) begin
          px = line_mem[mem_slot(oy - r + i, ox - r + j)];
          l = brightness(px);
          better = cfg_min ? (l < bl) : (l > bl);
          if (first || better) begin
            pick = px;
            bl = l;
            first = 1'b0;
          end
        end
      end
    end
    fin = (oy + 1 == h) && (ox + 1 == w);
    res.out_red = pick[23:16];
    res.out_green = pick[15:8];
    res.out_blue = pick[7:0];
    res.frame_last = fin;
    if (fin) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frame_closed = 1'b1;
    end else if (ox + 1 == w) begin
      out_col = 0;
      out_row = oy + 1;
    end else begin
      out_col = ox + 1;
    end
  endtask

  // predictor step for one accepted item
  task automatic filter_step(input wlmm_pkg::in_item_t it, output bit got,
                             output wlmm_pkg::out_item_t res);
    int unsigned w, h, r, d, lag;
    w = eff_width();
    h = eff_height();
    r = eff_radius();
    d = (r & 1) ? r : r - 1;
    lag = d * w + d;
    got = 1'b0;
    res = '0;
    if (in_row >= h) begin
      emit_result(res);
      got = 1'b1;
      return;
    end
    if (it.cmd == wlmm_pkg::CmdFlush) return;
    line_mem[mem_slot(in_row, in_col)] = {it.in_red, it.in_green, it.in_blue};
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    if (in_row * w + in_col > out_row * w + out_col + lag) begin
      emit_result(res);
      got = 1'b1;
    end
  endtask

  // offer one item, wait for acceptance, record the expected result
  task automatic send_item(wlmm_pkg::in_item_t it, bit typed = 1'b0,
                           wlmm_pkg::out_item_t typed_exp = '0);
    bit got;
    wlmm_pkg::out_item_t res;
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk_i); while (!in_ready);
    n_items++;
    filter_step(it, got, res);
    if (got) expected_q.push_back(typed ? typed_exp : res);
  endtask

  // drop valid, let every result arrive, then let the block settle
  task automatic drain_and_settle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_reg(wlmm_pkg::reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 4'(idx) << 2;
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      wlmm_pkg::RegMinMode: cfg_min = val[0];
      wlmm_pkg::RegRadius:  cfg_radius = val[2:0];
      wlmm_pkg::RegWidth:   cfg_width = val[10:0];
      default:              cfg_height = val[11:0];
    endcase
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic wlmm_pkg::in_item_t pixel(logic [23:0] rgb);
    wlmm_pkg::in_item_t it;
    it.cmd = wlmm_pkg::CmdPixel;
    {it.in_red, it.in_green, it.in_blue} = rgb;
    return it;
  endfunction

  function automatic wlmm_pkg::in_item_t flush_tick();
    wlmm_pkg::in_item_t it;
    it = wlmm_pkg::in_item_t'(25'($urandom));
    it.cmd = wlmm_pkg::CmdFlush;
    return it;
  endfunction

  function automatic wlmm_pkg::out_item_t result_px(logic [23:0] rgb, logic fin);
    return {rgb, fin};
  endfunction

  // directed stimulus rows
  typedef struct {
    bit                  is_cfg;
    wlmm_pkg::reg_idx_e  idx;
    logic [31:0]         val;
    wlmm_pkg::in_item_t  item;
    bit                  typed;
    wlmm_pkg::out_item_t exp_res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void add_cfg(wlmm_pkg::reg_idx_e idx, logic [31:0] val);
    dir_rows.push_back('{1'b1, idx, val, '0, 1'b0, '0});
  endfunction

  function automatic void add_item(wlmm_pkg::in_item_t it, bit typed = 1'b0,
                                   wlmm_pkg::out_item_t e = '0);
    dir_rows.push_back('{1'b0, wlmm_pkg::RegMinMode, '0, it, typed, e});
  endfunction

  function automatic logic [23:0] rand_rgb(int unsigned style);
    case (style)
      1: return {8'($urandom_range(1) * 8'h10), 8'h20, 8'($urandom_range(1))};
      2: return $urandom_range(1) ? 24'hffffff : 24'h000000;
      default: return 24'($urandom);
    endcase
  endfunction

  // one raster frame, possibly cut short or salted with stray items
  task automatic run_frame(bit cut_short);
    int unsigned total, stop, style;
    frame_closed = 1'b0;
    total = eff_width() * eff_height();
    stop = cut_short ? $urandom_range(total) : total;
    style = $urandom_range(3);
    for (int unsigned k = 0; k < stop; k++) begin
      if ($urandom_range(99) < 3) send_item(flush_tick());
      send_item(pixel(rand_rgb(style)));
    end
    if (cut_short) return;
    while (!frame_closed) begin
      if ($urandom_range(99) < 10) send_item(pixel(24'($urandom)));
      else send_item(flush_tick());
    end
    n_frames++;
  endtask

  // receiver: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (!hold_done && n_items >= 120) begin
      hold_done = 1'b1;
      out_ready = 1'b0;
      repeat (400) @(negedge clk_i);
    end
    out_ready = (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    wlmm_pkg::out_item_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", out_item);
        n_fail++;
      end else begin
        e = expected_q.pop_front();
        n_results++;
        if (out_item.out_red !== e.out_red) begin
          $error("out_red: expected %0h, got %0h", e.out_red, out_item.out_red);
          n_fail++;
        end
        if (out_item.out_green !== e.out_green) begin
          $error("out_green: expected %0h, got %0h", e.out_green, out_item.out_green);
          n_fail++;
        end
        if (out_item.out_blue !== e.out_blue) begin
          $error("out_blue: expected %0h, got %0h", e.out_blue, out_item.out_blue);
          n_fail++;
        end
        if (out_item.frame_last !== e.frame_last) begin
          $error("frame_last: expected %0b, got %0b", e.frame_last, out_item.frame_last);
          n_fail++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("window_luma_min_max_filter regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned r, w, h;
    send_idle_pct = 38;
    recv_idle_pct = 72;
    cfg_min = wlmm_pkg::RstMinMode;
    cfg_radius = wlmm_pkg::RstRadius;
    cfg_width = wlmm_pkg::RstWidth;
    cfg_height = wlmm_pkg::RstHeight;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // 1x1 frame, early flush, extra pixel, tie window, clamped registers
    add_cfg(wlmm_pkg::RegRadius, 1);
    add_cfg(wlmm_pkg::RegWidth, 1);
    add_cfg(wlmm_pkg::RegHeight, 1);
    add_item(pixel(24'hffffff));
    add_item(flush_tick(), 1'b1, result_px(24'hffffff, 1'b1));
    add_cfg(wlmm_pkg::RegWidth, 2);
    add_item(flush_tick());
    add_item(pixel(24'h000000));
    add_item(pixel(24'h123456));
    add_item(pixel(24'habcdef), 1'b1, result_px(24'h000000, 1'b0));
    add_item(flush_tick(), 1'b1, result_px(24'h123456, 1'b1));
    add_cfg(wlmm_pkg::RegWidth, 3);
    add_cfg(wlmm_pkg::RegHeight, 3);
    add_item(pixel(24'h000001));
    add_item(pixel(24'h010000));
    add_item(pixel(24'h000100));
    add_item(pixel(24'h000002));
    add_item(pixel(24'h020000));
    add_item(pixel(24'h000200));
    add_item(pixel(24'h000003));
    add_item(pixel(24'h030000));
    add_item(pixel(24'h000300));
    repeat (4) add_item(flush_tick());
    add_cfg(wlmm_pkg::RegRadius, 7);
    add_cfg(wlmm_pkg::RegWidth, 2047);
    add_cfg(wlmm_pkg::RegHeight, 4095);
    add_cfg(wlmm_pkg::RegMinMode, 1);
    add_item(pixel(24'h000000));
    add_item(pixel(24'hffffff));
    add_item(pixel(24'h808080));
    add_cfg(wlmm_pkg::RegRadius, 0);
    add_item(pixel(24'h5a5a5a));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain_and_settle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].exp_res);
      end
    end

    // random phases: new settings, then a few frames each
    while (n_items < ItemTarget) begin
      if (n_items >= 2 * ItemTarget / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (n_items >= ItemTarget / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 38;
      end
      drain_and_settle();
      case (n_phases)
        0: r = 1;
        1: r = 6;
        2: r = 0;
        3: r = 7;
        default: r = $urandom_range(1, 6);
      endcase
      if (n_phases == 4) begin
        w = $urandom_range(120, 200);
        h = 1;
      end else if (r >= 5 && $urandom_range(1)) begin
        w = $urandom_range(12, 18);
        h = $urandom_range(12, 18);
      end else begin
        w = $urandom_range(0, 14);
        h = $urandom_range(0, 14);
      end
      write_reg(wlmm_pkg::RegMinMode, $urandom_range(1));
      write_reg(wlmm_pkg::RegRadius, r);
      write_reg(wlmm_pkg::RegWidth, w);
      write_reg(wlmm_pkg::RegHeight, h);
      n_phases++;
      repeat ($urandom_range(1, 3)) begin
        if (n_items < ItemTarget) run_frame(1'b0);
      end
      if ($urandom_range(3) == 0 && n_items < ItemTarget) run_frame(1'b1);
    end

    @(negedge clk_i);
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    $display("covered %0d items, %0d results, %0d full frames over %0d register settings",
             n_items, n_results, n_frames, n_phases);
    $display("with both stall patterns, a long output hold-off and clamped register values");
    if (n_fail == 0) begin
      $display("window_luma_min_max_filter regression: pass");
    end else begin
      $display("window_luma_min_max_filter regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/wlmm_pkg.sv
src/wlmm_ram.sv
src/window_luma_min_max_filter.sv
verif/window_luma_min_max_filter_test.sv
